// ===== sv/dcs_pkg.sv =====
// Shared types and constants for the divisor count sieve block.
package dcs_pkg;

  localparam int TGT_W   = 8;
  localparam int RANGE_W = 17;
  localparam int COUNT_W = 17;
  localparam int EXP_W   = 5;

  typedef enum logic [11:0] {
    OP_CLR   = 12'b0000_0000_0001,
    OP_OCHK  = 12'b0000_0000_0010,
    OP_OTST  = 12'b0000_0000_0100,
    OP_IRD   = 12'b0000_0000_1000,
    OP_IWR   = 12'b0000_0001_0000,
    OP_DINIT = 12'b0000_0010_0000,
    OP_DRD1  = 12'b0000_0100_0000,
    OP_DRD2  = 12'b0000_1000_0000,
    OP_DCALC = 12'b0001_0000_0000,
    OP_DWR   = 12'b0010_0000_0000,
    OP_IDLE  = 12'b0100_0000_0000,
    OP_QRUN  = 12'b1000_0000_0000
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic outer_done;
    logic prime;
    logic inner_done;
    logic div_done;
    logic q_empty;
    logic q_last;
  } status_t;

endpackage

// ===== sv/dcs_datapath.sv =====
// Datapath: factor tables, divisor table, loop counters and query counter.
module dcs_datapath #(
  parameter int TABLE_LIMIT = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dcs_pkg::cmd_t                 cmd,
  input  logic [dcs_pkg::TGT_W-1:0]     target_divisors,
  input  logic [dcs_pkg::RANGE_W-1:0]   range_low,
  input  logic [dcs_pkg::RANGE_W-1:0]   range_high,
  output dcs_pkg::status_t              status,
  output logic [dcs_pkg::COUNT_W-1:0]   match_count
);
  localparam int AW    = $clog2(TABLE_LIMIT + 1);
  localparam int CW    = AW + 1;
  localparam int QW    = (CW > dcs_pkg::RANGE_W) ? CW : dcs_pkg::RANGE_W;
  localparam int DIV_W = (TABLE_LIMIT <= 65536) ? 8 : 11;
  localparam int XW    = dcs_pkg::EXP_W;
  localparam int TW    = (DIV_W > dcs_pkg::TGT_W) ? DIV_W : dcs_pkg::TGT_W;
  localparam logic [CW-1:0] LIM_C = CW'(TABLE_LIMIT);
  localparam logic [QW-1:0] LIM_Q = QW'(TABLE_LIMIT);
  localparam logic [dcs_pkg::COUNT_W-1:0] CNT_MAX = '1;

  logic [2*AW-1:0]     sieve_mem [0:TABLE_LIMIT];
  logic [XW+DIV_W-1:0] aux_mem   [0:TABLE_LIMIT];
  logic [DIV_W-1:0]    div_mem   [0:TABLE_LIMIT];

  logic [2*AW-1:0]     s_rd, s_wd;
  logic [XW+DIV_W-1:0] a_rd, a_wd;
  logic [DIV_W-1:0]    d_rd, d_wd;
  logic [AW-1:0]       s_ra, s_wa, a_ra, a_wa, d_ra, d_wa;
  logic                s_we, a_we, d_we;

  logic [CW-1:0] idx, hi, i, isq, j, n;
  logic [AW-1:0] k, p, m;
  logic [dcs_pkg::TGT_W-1:0] target;
  logic [dcs_pkg::COUNT_W-1:0] count;
  logic qv;
  logic [XW-1:0] exp_n;
  logic [DIV_W-1:0] rest_n;
  logic [DIV_W+XW:0] prod;
  logic [AW-1:0] rd_spf, rd_cof, m_spf;
  logic same;
  logic [QW-1:0] lo_q, hi_q, hi_cl;

  assign rd_spf = s_rd[2*AW-1:AW];
  assign rd_cof = s_rd[AW-1:0];
  assign m_spf  = rd_spf;
  assign same   = (m_spf == '0) ? (m == p) : (m_spf == p);
  assign prod   = rest_n * ({1'b0, exp_n} + (XW+1)'(1));

  assign lo_q  = QW'(range_low);
  assign hi_q  = QW'(range_high);
  assign hi_cl = (hi_q > LIM_Q) ? LIM_Q : hi_q;

  assign status.clr_last   = (idx == LIM_C);
  assign status.outer_done = (isq > LIM_C);
  assign status.prime      = (rd_spf == '0);
  assign status.inner_done = (j > LIM_C);
  assign status.div_done   = (n > LIM_C);
  assign status.q_empty    = (lo_q > hi_cl);
  assign status.q_last     = (idx == hi);
  assign match_count       = count;

  always_comb begin
    s_we = 1'b0; a_we = 1'b0; d_we = 1'b0;
    s_ra = '0; a_ra = '0; d_ra = '0;
    s_wa = '0; a_wa = '0; d_wa = '0;
    s_wd = '0; a_wd = '0; d_wd = '0;
    case (cmd.op)
      dcs_pkg::OP_CLR: begin
        s_we = 1'b1; s_wa = idx[AW-1:0];
        d_we = 1'b1; d_wa = idx[AW-1:0];
      end
      dcs_pkg::OP_OCHK: s_ra = i[AW-1:0];
      dcs_pkg::OP_IRD:  s_ra = j[AW-1:0];
      dcs_pkg::OP_IWR: begin
        s_we = (rd_spf == '0);
        s_wa = j[AW-1:0];
        s_wd = {i[AW-1:0], k};
      end
      dcs_pkg::OP_DINIT: begin
        d_we = 1'b1; d_wa = AW'(1); d_wd = DIV_W'(1);
      end
      dcs_pkg::OP_DRD1: s_ra = n[AW-1:0];
      dcs_pkg::OP_DRD2: begin
        if (rd_spf == '0) begin
          a_we = 1'b1; a_wa = n[AW-1:0]; a_wd = {XW'(1), DIV_W'(1)};
          d_we = 1'b1; d_wa = n[AW-1:0]; d_wd = DIV_W'(2);
        end else begin
          s_ra = rd_cof; a_ra = rd_cof; d_ra = rd_cof;
        end
      end
      dcs_pkg::OP_DWR: begin
        a_we = 1'b1; a_wa = n[AW-1:0]; a_wd = {exp_n, rest_n};
        d_we = 1'b1; d_wa = n[AW-1:0]; d_wd = prod[DIV_W-1:0];
      end
      dcs_pkg::OP_QRUN: d_ra = idx[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_we) sieve_mem[s_wa] <= s_wd;
    if (a_we) aux_mem[a_wa] <= a_wd;
    if (d_we) div_mem[d_wa] <= d_wd;
    s_rd <= sieve_mem[s_ra];
    a_rd <= aux_mem[a_ra];
    d_rd <= div_mem[d_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      qv    <= 1'b0;
      count <= '0;
    end else begin
      qv <= (cmd.op == dcs_pkg::OP_QRUN);
      case (cmd.op)
        dcs_pkg::OP_CLR: begin
          idx <= idx + CW'(1);
          i   <= CW'(2);
          isq <= CW'(4);
        end
        dcs_pkg::OP_OTST: begin
          if (rd_spf == '0) begin
            j <= isq;
            k <= i[AW-1:0];
          end else begin
            i   <= i + CW'(1);
            isq <= isq + {i[CW-2:0], 1'b1};
          end
        end
        dcs_pkg::OP_IRD: begin
          if (j > LIM_C) begin
            i   <= i + CW'(1);
            isq <= isq + {i[CW-2:0], 1'b1};
          end
        end
        dcs_pkg::OP_IWR: begin
          j <= j + i;
          k <= k + AW'(1);
        end
        dcs_pkg::OP_DINIT: n <= CW'(2);
        dcs_pkg::OP_DRD2: begin
          if (rd_spf == '0) begin
            n <= n + CW'(1);
          end else begin
            p <= rd_spf;
            m <= rd_cof;
          end
        end
        dcs_pkg::OP_DCALC: begin
          if (same) begin
            exp_n  <= a_rd[XW+DIV_W-1:DIV_W] + XW'(1);
            rest_n <= a_rd[DIV_W-1:0];
          end else begin
            exp_n  <= XW'(1);
            rest_n <= d_rd;
          end
        end
        dcs_pkg::OP_DWR: n <= n + CW'(1);
        dcs_pkg::OP_IDLE: begin
          if (cmd.load) begin
            target <= target_divisors;
            idx    <= lo_q[CW-1:0];
            hi     <= hi_cl[CW-1:0];
            count  <= '0;
          end
        end
        dcs_pkg::OP_QRUN: idx <= idx + CW'(1);
        default: ;
      endcase
      if (qv && (TW'(d_rd) == TW'(target)) && (count != CNT_MAX))
        count <= count + dcs_pkg::COUNT_W'(1);
    end
  end

endmodule

// ===== sv/dcs_ctrl.sv =====
// Controller: start-up table fill sequence and query sequencing.
module dcs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  dcs_pkg::status_t status,
  output dcs_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);
  typedef enum logic [13:0] {
    S_CLR   = 14'b00_0000_0000_0001,
    S_OCHK  = 14'b00_0000_0000_0010,
    S_OTST  = 14'b00_0000_0000_0100,
    S_IRD   = 14'b00_0000_0000_1000,
    S_IWR   = 14'b00_0000_0001_0000,
    S_DINIT = 14'b00_0000_0010_0000,
    S_DRD1  = 14'b00_0000_0100_0000,
    S_DRD2  = 14'b00_0000_1000_0000,
    S_DCALC = 14'b00_0001_0000_0000,
    S_DWR   = 14'b00_0010_0000_0000,
    S_IDLE  = 14'b00_0100_0000_0000,
    S_QRUN  = 14'b00_1000_0000_0000,
    S_QLAST = 14'b01_0000_0000_0000,
    S_QOUT  = 14'b10_0000_0000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_QOUT);
  assign accept = start && !busy;

  always_comb begin
    cmd.load  = accept;
    case (state)
      S_CLR:   cmd.op = dcs_pkg::OP_CLR;
      S_OCHK:  cmd.op = dcs_pkg::OP_OCHK;
      S_OTST:  cmd.op = dcs_pkg::OP_OTST;
      S_IRD:   cmd.op = dcs_pkg::OP_IRD;
      S_IWR:   cmd.op = dcs_pkg::OP_IWR;
      S_DINIT: cmd.op = dcs_pkg::OP_DINIT;
      S_DRD1:  cmd.op = dcs_pkg::OP_DRD1;
      S_DRD2:  cmd.op = dcs_pkg::OP_DRD2;
      S_DCALC: cmd.op = dcs_pkg::OP_DCALC;
      S_DWR:   cmd.op = dcs_pkg::OP_DWR;
      S_QRUN:  cmd.op = dcs_pkg::OP_QRUN;
      default: cmd.op = dcs_pkg::OP_IDLE;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLR:   if (status.clr_last) state_next = S_OCHK;
      S_OCHK:  state_next = status.outer_done ? S_DINIT : S_OTST;
      S_OTST:  state_next = status.prime ? S_IRD : S_OCHK;
      S_IRD:   state_next = status.inner_done ? S_OCHK : S_IWR;
      S_IWR:   state_next = S_IRD;
      S_DINIT: state_next = S_DRD1;
      S_DRD1:  state_next = status.div_done ? S_IDLE : S_DRD2;
      S_DRD2:  state_next = status.prime ? S_DRD1 : S_DCALC;
      S_DCALC: state_next = S_DWR;
      S_DWR:   state_next = S_DRD1;
      S_IDLE:  if (accept) state_next = status.q_empty ? S_QOUT : S_QRUN;
      S_QRUN:  if (status.q_last) state_next = S_QLAST;
      S_QLAST: state_next = S_QOUT;
      S_QOUT:  state_next = S_IDLE;
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/divisor_count_sieve_range_query.sv =====
// Top level of the divisor count sieve range query block.
// After reset the block builds its tables and holds busy high: a clearing
// pass over all TABLE_LIMIT+1 entries, a sieve that reads each multiple
// visited and marks it if unmarked, then a divisor pass that writes each
// prime's entry at once and derives each composite's count from its
// cofactor. A query beat is taken when start is high and busy low; it then
// makes one divisor table read per number, or none for an empty range. The
// result is shown for one cycle with done high and cannot be held off.
module divisor_count_sieve_range_query #(
  parameter int TABLE_LIMIT = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  output logic                        done,
  input  logic [dcs_pkg::TGT_W-1:0]   target_divisors,
  input  logic [dcs_pkg::RANGE_W-1:0] range_low,
  input  logic [dcs_pkg::RANGE_W-1:0] range_high,
  output logic [dcs_pkg::COUNT_W-1:0] match_count
);
  dcs_pkg::cmd_t    cmd;
  dcs_pkg::status_t status;

  dcs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  dcs_datapath #(.TABLE_LIMIT(TABLE_LIMIT)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .target_divisors (target_divisors),
    .range_low       (range_low),
    .range_high      (range_high),
    .status          (status),
    .match_count     (match_count)
  );

endmodule

// ===== sv/dcs_checker.sv =====
// Port-level checker for the divisor count sieve block, with its bind.
module dcs_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("query beat not taken");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy held after result");

endmodule

bind divisor_count_sieve_range_query dcs_checker u_dcs_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
